/* rtl/crc16fc_pkg.sv */
// Package for the CRC-16 frame checker: status codes, register indexes,
// reset values and the one-byte CRC update function.
// No dependencies; crc16_frame_checker_top imports it.
package crc16fc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CrcW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned RawW     = 16;
  localparam int unsigned MvW      = 17;
  localparam int unsigned ProdW    = 29;
  localparam int unsigned MvShift  = 12;

  localparam logic [CrcW-1:0]  CRC_POLY  = 16'hA001;
  localparam logic [ProdW-1:0] MV_SCALE  = 29'd6600;
  localparam logic [ByteW-1:0] IDX_MAX   = 8'd255;
  // A frame needs two sync bytes and two CRC bytes, so a last byte at
  // position two or lower ends a frame that is too short.
  localparam logic [ByteW-1:0] SHORT_LAST_POS = 8'd2;
  localparam logic [ByteW-1:0] SYNC1_POS = 8'd0;
  localparam logic [ByteW-1:0] SYNC2_POS = 8'd1;
  localparam logic [ByteW-1:0] CRC_START_POS = 8'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEVICE_OFS   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_COUNTER_OFS  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_VOLT_HI_OFS  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_VOLT_LO_OFS  = 3'd5;

  // Register reset values.
  localparam logic [ByteW-1:0] RST_SYNC_FIRST  = 8'hAA;
  localparam logic [ByteW-1:0] RST_SYNC_SECOND = 8'hCC;
  localparam logic [ByteW-1:0] RST_DEVICE_OFS  = 8'd2;
  localparam logic [ByteW-1:0] RST_COUNTER_OFS = 8'd3;
  localparam logic [ByteW-1:0] RST_VOLT_HI_OFS = 8'd4;
  localparam logic [ByteW-1:0] RST_VOLT_LO_OFS = 8'd5;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_SYNC  = 2'd1,
    STATUS_BAD_CRC   = 2'd2,
    STATUS_TOO_SHORT = 2'd3
  } status_e;

  // Reflected CRC-16 update over one byte, least significant bit first.
  function automatic logic [CrcW-1:0] crc_absorb(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/crc16fc_in_if.sv */
// Input channel of the CRC-16 frame checker: one received frame byte per word.
// Depends on nothing but the ready/valid convention of the block.
interface crc16fc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source(output valid, output rx_byte, output last_byte, input ready);
  modport sink(input valid, input rx_byte, input last_byte, output ready);
endinterface

/* rtl/crc16fc_out_if.sv */
// Result channel of the CRC-16 frame checker: one word per finished frame.
// Depends on nothing but the ready/valid convention of the block.
interface crc16fc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [7:0]  device_id;
  logic [7:0]  packet_count;
  logic [15:0] battery_raw;
  logic [16:0] battery_millivolts;

  modport source(output valid, output frame_status, output device_id,
                 output packet_count, output battery_raw,
                 output battery_millivolts, input ready);
  modport sink(input valid, input frame_status, input device_id,
               input packet_count, input battery_raw,
               input battery_millivolts, output ready);
endinterface

/* rtl/crc16_frame_checker_top.sv */
// CRC-16 telemetry frame checker. The block takes one frame byte per clock
// cycle and checks each frame in a single pass: the sync bytes are compared,
// the reflected CRC-16 update of a byte (eight shift steps, unrolled) runs
// when the byte leaves a two-byte delay line, and the device id, packet
// counter and battery word are captured at their configured positions. The
// last byte of a frame loads the result register, whose word appears in the
// next cycle; other bytes give no result. The CRC update is combinational;
// input ready drops only while a finished result waits to be taken. The user
// must write configuration only while no frame is in flight; the block itself
// does not enforce it. Depends on crc16fc_pkg, crc16fc_in_if, crc16fc_out_if.
module crc16_frame_checker_top
  import crc16fc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ByteW-1:0]     cfg_data_i,
  crc16fc_in_if.sink           frame_i,
  crc16fc_out_if.source        result_o
);

  // Configuration registers.
  logic [ByteW-1:0] sync_first_q, sync_second_q;
  logic [ByteW-1:0] device_ofs_q, counter_ofs_q, volt_hi_ofs_q, volt_lo_ofs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= RST_SYNC_FIRST;
      sync_second_q <= RST_SYNC_SECOND;
      device_ofs_q  <= RST_DEVICE_OFS;
      counter_ofs_q <= RST_COUNTER_OFS;
      volt_hi_ofs_q <= RST_VOLT_HI_OFS;
      volt_lo_ofs_q <= RST_VOLT_LO_OFS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        CFG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        CFG_DEVICE_OFS:  device_ofs_q  <= cfg_data_i;
        CFG_COUNTER_OFS: counter_ofs_q <= cfg_data_i;
        CFG_VOLT_HI_OFS: volt_hi_ofs_q <= cfg_data_i;
        CFG_VOLT_LO_OFS: volt_lo_ofs_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame state.
  logic [ByteW-1:0] byte_idx_q, byte_idx_d;
  logic [CrcW-1:0]  crc_q, crc_d;
  logic [ByteW-1:0] older_q, older_d, newer_q, newer_d;
  logic             sync_good_q, sync_good_d;
  logic [ByteW-1:0] held_dev_q, held_dev_d, held_cnt_q, held_cnt_d;
  logic [ByteW-1:0] held_vhi_q, held_vhi_d, held_vlo_q, held_vlo_d;

  // Result register.
  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [ByteW-1:0] out_dev_q, out_cnt_q;
  logic [RawW-1:0]  out_raw_q, out_raw_d;
  logic [MvW-1:0]   out_mv_q, out_mv_d;
  logic [ProdW-1:0] mv_prod;

  logic in_acc, out_acc, in_ready;
  logic [ByteW-1:0] pos, b;

  assign out_acc  = out_valid_q && result_o.ready;
  assign in_ready = !out_valid_q || result_o.ready;
  assign in_acc   = frame_i.valid && in_ready;
  assign pos      = byte_idx_q;
  assign b        = frame_i.rx_byte;

  always_comb begin
    sync_good_d = sync_good_q;
    if ((pos == SYNC1_POS && b != sync_first_q) ||
        (pos == SYNC2_POS && b != sync_second_q)) begin
      sync_good_d = 1'b0;
    end
    held_dev_d = (pos == device_ofs_q)  ? b : held_dev_q;
    held_cnt_d = (pos == counter_ofs_q) ? b : held_cnt_q;
    held_vhi_d = (pos == volt_hi_ofs_q) ? b : held_vhi_q;
    held_vlo_d = (pos == volt_lo_ofs_q) ? b : held_vlo_q;
    // The byte leaving the two-byte delay line is the one the CRC covers.
    crc_d      = (pos >= CRC_START_POS) ? crc_absorb(crc_q, older_q) : crc_q;
    older_d    = newer_q;
    newer_d    = b;
    byte_idx_d = (byte_idx_q == IDX_MAX) ? IDX_MAX : byte_idx_q + 8'd1;

    if (pos <= SHORT_LAST_POS) begin
      out_status_d = STATUS_TOO_SHORT;
    end else if (!sync_good_d) begin
      out_status_d = STATUS_BAD_SYNC;
    end else if (older_d != crc_d[15:8] || newer_d != crc_d[7:0]) begin
      out_status_d = STATUS_BAD_CRC;
    end else begin
      out_status_d = STATUS_OK;
    end

    out_raw_d = {held_vhi_d, held_vlo_d};
    mv_prod   = ProdW'(out_raw_d) * MV_SCALE;
    out_mv_d  = mv_prod[ProdW-1:MvShift];

    out_valid_d = out_valid_q && !result_o.ready;
    if (in_acc && frame_i.last_byte) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q  <= '0;
      crc_q       <= '0;
      older_q     <= '0;
      newer_q     <= '0;
      sync_good_q <= 1'b1;
      held_dev_q  <= '0;
      held_cnt_q  <= '0;
      held_vhi_q  <= '0;
      held_vlo_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        if (frame_i.last_byte) begin
          // The frame is done; start the next one from a clean state.
          byte_idx_q  <= '0;
          crc_q       <= '0;
          older_q     <= '0;
          newer_q     <= '0;
          sync_good_q <= 1'b1;
          held_dev_q  <= '0;
          held_cnt_q  <= '0;
          held_vhi_q  <= '0;
          held_vlo_q  <= '0;
        end else begin
          byte_idx_q  <= byte_idx_d;
          crc_q       <= crc_d;
          older_q     <= older_d;
          newer_q     <= newer_d;
          sync_good_q <= sync_good_d;
          held_dev_q  <= held_dev_d;
          held_cnt_q  <= held_cnt_d;
          held_vhi_q  <= held_vhi_d;
          held_vlo_q  <= held_vlo_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && frame_i.last_byte) begin
      out_status_q <= out_status_d;
      out_dev_q    <= held_dev_d;
      out_cnt_q    <= held_cnt_d;
      out_raw_q    <= out_raw_d;
      out_mv_q     <= out_mv_d;
    end
  end

  assign frame_i.ready               = in_ready;
  assign result_o.valid              = out_valid_q;
  assign result_o.frame_status       = out_status_q;
  assign result_o.device_id          = out_dev_q;
  assign result_o.packet_count       = out_cnt_q;
  assign result_o.battery_raw        = out_raw_q;
  assign result_o.battery_millivolts = out_mv_q;

  a_last_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && frame_i.last_byte) |=> out_valid_q)
    else $error("last byte accepted but no result loaded");

  a_last_restarts_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && frame_i.last_byte) |=> (byte_idx_q == '0 && crc_q == '0 && sync_good_q))
    else $error("frame state not cleared after last byte");

  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !frame_i.last_byte && byte_idx_q != IDX_MAX)
      |=> byte_idx_q == $past(byte_idx_q) + 8'd1)
    else $error("byte index did not advance");

  a_short_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && frame_i.last_byte && byte_idx_q <= SHORT_LAST_POS)
      |=> out_status_q == STATUS_TOO_SHORT)
    else $error("short frame not flagged");

  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |-> !in_acc)
    else $error("byte accepted while result stalled");

endmodule
